// ----- rtl/core/segment_triangle_intersection_macros.svh -----
// ----------------------------------------------------------------------------
// Segment/triangle intersection assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_TRIANGLE_INTERSECTION_MACROS_SVH
`define SEGMENT_TRIANGLE_INTERSECTION_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STIP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/stip_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment/triangle intersection package
// Widths, pipeline latencies, register indexes and vector types.
// ----------------------------------------------------------------------------
package stip_pkg;

  localparam int W_C    = 32;
  localparam int W_E    = W_C + 1;
  localparam int W_N    = 2 * W_E + 1;
  localparam int W_DOT  = W_N + W_E + 2;
  localparam int W_EDOT = 2 * W_N + 2;
  localparam int W_T    = 17;
  localparam int T_ONE  = 65536;

  localparam int MUL_LAT   = 2;
  localparam int PLANE_LAT = 2 * MUL_LAT + 4;
  localparam int DIV_LAT   = MUL_LAT + 1 + W_C;
  localparam int EDGE_LAT  = 2 * MUL_LAT + 3;
  localparam int LAT_TOTAL = PLANE_LAT + DIV_LAT + EDGE_LAT + 2;

  localparam logic [2:0] REG_START_X = 3'd0;
  localparam logic [2:0] REG_START_Y = 3'd1;
  localparam logic [2:0] REG_START_Z = 3'd2;
  localparam logic [2:0] REG_END_X   = 3'd3;
  localparam logic [2:0] REG_END_Y   = 3'd4;
  localparam logic [2:0] REG_END_Z   = 3'd5;

  typedef logic [2:0][W_C-1:0]      vec_t;
  typedef logic [2:0][W_E-1:0]      dvec_t;
  typedef logic [2:0][W_N-1:0]      nvec_t;
  typedef logic [2:0][2:0][W_C-1:0] tri_t;

endpackage

// ----- rtl/core/stip_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined signed multiplier
// Splits both operands into 32-bit limbs, registers the limb products and
// sums them in a second stage.
// ----------------------------------------------------------------------------
module stip_mul #(
  parameter int WA = stip_pkg::W_E,
  parameter int WB = stip_pkg::W_E
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int NA = (WA + 31) / 32;
  localparam int NB = (WB + 31) / 32;
  localparam int WP = WA + WB;

  logic signed [NA*32-1:0] a_x;
  logic signed [NB*32-1:0] b_x;
  logic signed [32:0]      a_c [NA];
  logic signed [32:0]      b_c [NB];
  logic signed [65:0]      pp_r [NA][NB];
  logic signed [WP-1:0]    acc;
  logic signed [WP-1:0]    p_r;

  assign a_x = (NA*32)'(a);
  assign b_x = (NB*32)'(b);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      a_c[i] = (i == NA - 1) ? {a_x[i*32+31], a_x[i*32 +: 32]} : {1'b0, a_x[i*32 +: 32]};
    end
    for (int j = 0; j < NB; j++) begin
      b_c[j] = (j == NB - 1) ? {b_x[j*32+31], b_x[j*32 +: 32]} : {1'b0, b_x[j*32 +: 32]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= a_c[i] * b_c[j];
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (WP'(pp_r[i][j]) <<< (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= acc;
    end
  end

  assign p = p_r;

endmodule

// ----- rtl/core/stip_dly.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipeline delay line
// Carries side data alongside the arithmetic for a fixed number of stages.
// ----------------------------------------------------------------------------
module stip_dly #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < D; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[D-1];

endmodule

// ----- rtl/core/stip_plane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plane crossing front end
// Forms the triangle normal and the two dot products of the crossing
// parameter, folds the sign of the denominator and flags a miss.
// ----------------------------------------------------------------------------
module stip_plane (
  input  logic                             clk,
  input  logic                             en,
  input  stip_pkg::tri_t                   v,
  input  stip_pkg::vec_t                   s,
  input  stip_pkg::dvec_t                  d,
  output logic [stip_pkg::W_DOT-1:0]       num_o,
  output logic [stip_pkg::W_DOT-1:0]       den_o,
  output logic                             miss_o,
  output stip_pkg::nvec_t                  n_o
);

  localparam int WE = stip_pkg::W_E;
  localparam int WN = stip_pkg::W_N;
  localparam int WD = stip_pkg::W_DOT;

  stip_pkg::dvec_t       e0_r, e1_r, rel_r, rel_d;
  stip_pkg::nvec_t       n_r;
  logic signed [2*WE-1:0] xa [3];
  logic signed [2*WE-1:0] xb [3];
  logic signed [WN+WE-1:0] dn [3];
  logic signed [WN+WE-1:0] dd [3];
  logic signed [WD-1:0]  num_r, den_r, num_s, den_s, gap;
  logic [WD-1:0]         num_o_r, den_o_r;
  logic                  miss_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e0_r[k]  <= WE'($signed(v[1][k])) - WE'($signed(v[0][k]));
        e1_r[k]  <= WE'($signed(v[2][k])) - WE'($signed(v[0][k]));
        rel_r[k] <= WE'($signed(v[0][k])) - WE'($signed(s[k]));
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_cross
    localparam int K1 = (k + 1) % 3;
    localparam int K2 = (k + 2) % 3;
    stip_mul #(.WA(WE), .WB(WE)) u_ma (
      .clk(clk), .en(en), .a(e0_r[K1]), .b(e1_r[K2]), .p(xa[k])
    );
    stip_mul #(.WA(WE), .WB(WE)) u_mb (
      .clk(clk), .en(en), .a(e0_r[K2]), .b(e1_r[K1]), .p(xb[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        n_r[k] <= WN'(xa[k]) - WN'(xb[k]);
      end
    end
  end

  stip_dly #(.W(3 * WE), .D(stip_pkg::MUL_LAT + 1)) u_rel_dly (
    .clk(clk), .en(en), .d(rel_r), .q(rel_d)
  );

  for (genvar k = 0; k < 3; k++) begin : g_dot
    stip_mul #(.WA(WN), .WB(WE)) u_mn (
      .clk(clk), .en(en), .a(n_r[k]), .b(rel_d[k]), .p(dn[k])
    );
    stip_mul #(.WA(WN), .WB(WE)) u_md (
      .clk(clk), .en(en), .a(n_r[k]), .b(d[k]), .p(dd[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= WD'(dn[0]) + WD'(dn[1]) + WD'(dn[2]);
      den_r <= WD'(dd[0]) + WD'(dd[1]) + WD'(dd[2]);
    end
  end

  always_comb begin
    num_s = den_r[WD-1] ? -num_r : num_r;
    den_s = den_r[WD-1] ? -den_r : den_r;
    gap   = den_s - num_s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_o_r <= num_s;
      den_o_r <= den_s;
      miss_r  <= (den_r == '0) || num_s[WD-1] || gap[WD-1];
    end
  end

  stip_dly #(.W(3 * WN), .D(stip_pkg::MUL_LAT + 2)) u_n_dly (
    .clk(clk), .en(en), .d(n_r), .q(n_o)
  );

  assign num_o  = num_o_r;
  assign den_o  = den_o_r;
  assign miss_o = miss_r;

endmodule

// ----- rtl/core/stip_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rounding divider lane
// Computes round(x * num / den) for 0 <= num <= den with a pipelined
// restoring division, one quotient bit per stage.
// ----------------------------------------------------------------------------
module stip_div #(
  parameter int W_NUM = stip_pkg::W_DOT,
  parameter int W_X   = stip_pkg::W_C
) (
  input  logic             clk,
  input  logic             en,
  input  logic [W_NUM-1:0] num,
  input  logic [W_NUM-1:0] den,
  input  logic [W_X-1:0]   x,
  output logic [W_X-1:0]   q
);

  localparam int WDV = W_NUM + W_X + 2;
  localparam int WB  = W_NUM + 1;
  localparam int WR  = W_NUM + 2;

  logic signed [WDV-1:0] prod;
  logic [W_NUM-1:0]      den_d;
  logic [WDV-1:0]        dvd;
  logic [WR-1:0]         rem_r [W_X+1];
  logic [W_X-1:0]        low_r [W_X+1];
  logic [W_X-1:0]        q_r   [W_X+1];
  logic [WB-1:0]         b_r   [W_X+1];
  logic [WR-1:0]         rs    [W_X];
  logic [WR-1:0]         rn    [W_X];
  logic                  ge    [W_X];

  stip_mul #(.WA(W_NUM + 1), .WB(W_X + 1)) u_mul (
    .clk(clk), .en(en), .a({1'b0, num}), .b({1'b0, x}), .p(prod)
  );

  stip_dly #(.W(W_NUM), .D(stip_pkg::MUL_LAT)) u_den_dly (
    .clk(clk), .en(en), .d(den), .q(den_d)
  );

  assign dvd = {prod[WDV-2:0], 1'b0} + WDV'(den_d);

  always_comb begin
    for (int s = 0; s < W_X; s++) begin
      rs[s] = {rem_r[s][WR-2:0], low_r[s][W_X-1]};
      ge[s] = rs[s] >= WR'(b_r[s]);
      rn[s] = ge[s] ? rs[s] - WR'(b_r[s]) : rs[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= dvd[WDV-1:W_X];
      low_r[0] <= dvd[W_X-1:0];
      q_r[0]   <= '0;
      b_r[0]   <= {den_d, 1'b0};
      for (int s = 0; s < W_X; s++) begin
        rem_r[s+1] <= rn[s];
        low_r[s+1] <= {low_r[s][W_X-2:0], 1'b0};
        q_r[s+1]   <= {q_r[s][W_X-2:0], ge[s]};
        b_r[s+1]   <= b_r[s];
      end
    end
  end

  assign q = q_r[W_X];

endmodule

// ----- rtl/core/stip_edge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge side test
// Checks that the crossing point lies on the inner side of all three
// triangle edges, a point on an edge counting as inside.
// ----------------------------------------------------------------------------
module stip_edge (
  input  logic            clk,
  input  logic            en,
  input  stip_pkg::tri_t  v,
  input  stip_pkg::vec_t  p,
  input  stip_pkg::nvec_t n,
  output logic            ok
);

  localparam int WE = stip_pkg::W_E;
  localparam int WN = stip_pkg::W_N;
  localparam int WS = stip_pkg::W_EDOT;

  stip_pkg::dvec_t        ed_r [3];
  stip_pkg::dvec_t        rl_r [3];
  stip_pkg::nvec_t        c_r  [3];
  stip_pkg::nvec_t        n_d;
  logic signed [2*WE-1:0] xa [3][3];
  logic signed [2*WE-1:0] xb [3][3];
  logic signed [2*WN-1:0] dp [3][3];
  logic signed [WS-1:0]   sum [3];
  logic                   ok_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          ed_r[i][k] <= WE'($signed(v[(i == 2) ? 0 : i + 1][k])) - WE'($signed(v[i][k]));
          rl_r[i][k] <= WE'($signed(p[k])) - WE'($signed(v[i][k]));
        end
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_edge
    for (genvar k = 0; k < 3; k++) begin : g_axis
      localparam int K1 = (k + 1) % 3;
      localparam int K2 = (k + 2) % 3;
      stip_mul #(.WA(WE), .WB(WE)) u_ma (
        .clk(clk), .en(en), .a(ed_r[i][K1]), .b(rl_r[i][K2]), .p(xa[i][k])
      );
      stip_mul #(.WA(WE), .WB(WE)) u_mb (
        .clk(clk), .en(en), .a(ed_r[i][K2]), .b(rl_r[i][K1]), .p(xb[i][k])
      );
      stip_mul #(.WA(WN), .WB(WN)) u_md (
        .clk(clk), .en(en), .a(c_r[i][k]), .b(n_d[k]), .p(dp[i][k])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          c_r[i][k] <= WN'(xa[i][k]) - WN'(xb[i][k]);
        end
      end
    end
  end

  stip_dly #(.W(3 * WN), .D(stip_pkg::MUL_LAT + 2)) u_n_dly (
    .clk(clk), .en(en), .d(n), .q(n_d)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = WS'(dp[i][0]) + WS'(dp[i][1]) + WS'(dp[i][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok_r <= !sum[0][WS-1] && !sum[1][WS-1] && !sum[2][WS-1];
    end
  end

  assign ok = ok_r;

endmodule

// ----- rtl/core/segment_triangle_intersection.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment/triangle intersection
// Tests a stream of triangles against a configured pick segment and returns
// the hit flag, the crossing parameter and the rounded crossing point.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Beat
// in       input      in_valid/in_ready    one triangle, three Q16.16 vertices
// out      output     out_valid/out_ready  hit, t (Q1.16), point (Q16.16)
// cfg      input      cfg_we               one segment coordinate register
//
// One beat is taken every cycle unless the output stalls. A triangle passes
// through the plane front end, the rounding divider lanes, the point registers,
// the edge test and the output registers.
// Reset clears the segment registers and the pipeline valid bits.
// A stall at the output holds the whole pipeline, so nothing is lost.
// ----------------------------------------------------------------------------
module segment_triangle_intersection (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_v0_x,
  input  logic [31:0] in_v0_y,
  input  logic [31:0] in_v0_z,
  input  logic [31:0] in_v1_x,
  input  logic [31:0] in_v1_y,
  input  logic [31:0] in_v1_z,
  input  logic [31:0] in_v2_x,
  input  logic [31:0] in_v2_y,
  input  logic [31:0] in_v2_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [16:0] out_t_param,
  output logic [31:0] out_hit_x,
  output logic [31:0] out_hit_y,
  output logic [31:0] out_hit_z,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_wdata
);

  localparam int WC  = stip_pkg::W_C;
  localparam int WE  = stip_pkg::W_E;
  localparam int WN  = stip_pkg::W_N;
  localparam int WD  = stip_pkg::W_DOT;
  localparam int WT  = stip_pkg::W_T;
  localparam int LAT = stip_pkg::LAT_TOTAL;
  localparam int WQ  = 1 + WT + 3 * WC;

  stip_pkg::vec_t  start_r, end_r, p_r;
  stip_pkg::dvec_t seg_d, dabs;
  stip_pkg::tri_t  v_in, v_d;
  stip_pkg::nvec_t n_p, n_d;
  logic [WD-1:0]   num_p, den_p;
  logic            miss_p, miss_d, miss_e, ok_e;
  logic [WC-1:0]   xs  [4];
  logic [WC-1:0]   q_l [4];
  logic [WT-1:0]   t_r, t_e;
  stip_pkg::vec_t  p_e;
  logic [WQ-1:0]   res_e;
  logic            en;
  logic            vld_r [LAT];
  logic            hit_r;
  logic [WT-1:0]   t_out_r;
  stip_pkg::vec_t  pt_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        stip_pkg::REG_START_X: start_r[0] <= cfg_wdata;
        stip_pkg::REG_START_Y: start_r[1] <= cfg_wdata;
        stip_pkg::REG_START_Z: start_r[2] <= cfg_wdata;
        stip_pkg::REG_END_X:   end_r[0]   <= cfg_wdata;
        stip_pkg::REG_END_Y:   end_r[1]   <= cfg_wdata;
        stip_pkg::REG_END_Z:   end_r[2]   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      seg_d[k] = WE'($signed(end_r[k])) - WE'($signed(start_r[k]));
      dabs[k]  = seg_d[k][WE-1] ? -seg_d[k] : seg_d[k];
    end
  end

  assign en       = !vld_r[LAT-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign v_in[0] = {in_v0_z, in_v0_y, in_v0_x};
  assign v_in[1] = {in_v1_z, in_v1_y, in_v1_x};
  assign v_in[2] = {in_v2_z, in_v2_y, in_v2_x};

  stip_plane u_plane (
    .clk(clk), .en(en), .v(v_in), .s(start_r), .d(seg_d),
    .num_o(num_p), .den_o(den_p), .miss_o(miss_p), .n_o(n_p)
  );

  assign xs[0] = WC'(stip_pkg::T_ONE);
  assign xs[1] = dabs[0][WC-1:0];
  assign xs[2] = dabs[1][WC-1:0];
  assign xs[3] = dabs[2][WC-1:0];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    stip_div #(.W_NUM(WD), .W_X(WC)) u_div (
      .clk(clk), .en(en), .num(num_p), .den(den_p), .x(xs[l]), .q(q_l[l])
    );
  end

  stip_dly #(.W(1 + 3 * WN), .D(stip_pkg::DIV_LAT + 1)) u_plane_dly (
    .clk(clk), .en(en), .d({miss_p, n_p}), .q({miss_d, n_d})
  );

  stip_dly #(.W(9 * WC), .D(stip_pkg::PLANE_LAT + stip_pkg::DIV_LAT + 1)) u_v_dly (
    .clk(clk), .en(en), .d(v_in), .q(v_d)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= q_l[0][WT-1:0];
      for (int k = 0; k < 3; k++) begin
        p_r[k] <= start_r[k] + (seg_d[k][WE-1] ? -q_l[k+1] : q_l[k+1]);
      end
    end
  end

  stip_edge u_edge (
    .clk(clk), .en(en), .v(v_d), .p(p_r), .n(n_d), .ok(ok_e)
  );

  stip_dly #(.W(WQ), .D(stip_pkg::EDGE_LAT)) u_res_dly (
    .clk(clk), .en(en), .d({miss_d, t_r, p_r}), .q(res_e)
  );

  assign {miss_e, t_e, p_e} = res_e;

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r    <= !miss_e && ok_e;
      t_out_r  <= miss_e ? '0 : t_e;
      pt_out_r <= miss_e ? '0 : p_e;
    end
  end

  assign out_valid   = vld_r[LAT-1];
  assign out_hit     = hit_r;
  assign out_t_param = t_out_r;
  assign out_hit_x   = pt_out_r[0];
  assign out_hit_y   = pt_out_r[1];
  assign out_hit_z   = pt_out_r[2];

`include "segment_triangle_intersection_macros.svh"

  `STIP_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld_r[0], "accepted beat lost")
  `STIP_ASSERT_NOW(a_stall_blocks, out_valid && !out_ready, !in_ready, "input taken in stall")
  `STIP_ASSERT_NOW(a_t_range, out_valid && out_hit, out_t_param <= WT'(stip_pkg::T_ONE), "t above one")

endmodule

// ----- tb/stip_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment/triangle intersection checker
// Watches the configuration port and both channels, works out the exact
// crossing of every accepted triangle with the pick segment and compares each
// result beat, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module stip_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_v0_x,
  input  logic [31:0] in_v0_y,
  input  logic [31:0] in_v0_z,
  input  logic [31:0] in_v1_x,
  input  logic [31:0] in_v1_y,
  input  logic [31:0] in_v1_z,
  input  logic [31:0] in_v2_x,
  input  logic [31:0] in_v2_y,
  input  logic [31:0] in_v2_z,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_hit,
  input  logic [16:0] out_t_param,
  input  logic [31:0] out_hit_x,
  input  logic [31:0] out_hit_y,
  input  logic [31:0] out_hit_z,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_wdata,
  output int          errors,
  output int          pending
);

  typedef logic signed [255:0] w_t;
  typedef struct { w_t x, y, z; } wv_t;
  typedef struct {
    logic        hit;
    logic [16:0] t;
    logic [31:0] x, y, z;
  } crossing_t;

  logic signed [31:0] seg_start [3];
  logic signed [31:0] seg_end [3];
  crossing_t expected_crossings [$];

  function automatic wv_t vsub(wv_t a, wv_t b);
    wv_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic wv_t cross3(wv_t a, wv_t b);
    wv_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  function automatic w_t dot3(wv_t a, wv_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  // Nearest, ties away from zero; den is positive.
  function automatic w_t round_quot(w_t num, w_t den);
    logic        neg;
    logic [255:0] mag;
    logic [255:0] q;
    neg = num < 0;
    mag = neg ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return neg ? -$signed(q) : $signed(q);
  endfunction

  function automatic wv_t widen(logic signed [31:0] a, logic signed [31:0] b,
                                logic signed [31:0] c);
    wv_t r;
    r.x = w_t'(a);
    r.y = w_t'(b);
    r.z = w_t'(c);
    return r;
  endfunction

  function automatic crossing_t plane_crossing(wv_t v0, wv_t v1, wv_t v2);
    crossing_t res;
    wv_t s, d, n, p;
    wv_t vert [3];
    w_t num, den, tq;
    logic in_tri;
    res = '{default: '0};
    vert[0] = v0;
    vert[1] = v1;
    vert[2] = v2;
    s = widen(seg_start[0], seg_start[1], seg_start[2]);
    d = vsub(widen(seg_end[0], seg_end[1], seg_end[2]), s);
    n = cross3(vsub(v1, v0), vsub(v2, v0));
    num = dot3(n, vsub(v0, s));
    den = dot3(n, d);
    if (den == 0) return res;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (num < 0 || num > den) return res;
    p.x = s.x + round_quot(d.x * num, den);
    p.y = s.y + round_quot(d.y * num, den);
    p.z = s.z + round_quot(d.z * num, den);
    in_tri = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (dot3(cross3(vsub(vert[(i + 1) % 3], vert[i]), vsub(p, vert[i])), n) < 0)
        in_tri = 1'b0;
    end
    tq = round_quot(num * 65536, den);
    res.hit = in_tri;
    res.t = tq[16:0];
    res.x = p.x[31:0];
    res.y = p.y[31:0];
    res.z = p.z[31:0];
    return res;
  endfunction

  assign pending = expected_crossings.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      seg_start <= '{default: '0};
      seg_end <= '{default: '0};
      expected_crossings.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          stip_pkg::REG_START_X: seg_start[0] <= cfg_wdata;
          stip_pkg::REG_START_Y: seg_start[1] <= cfg_wdata;
          stip_pkg::REG_START_Z: seg_start[2] <= cfg_wdata;
          stip_pkg::REG_END_X:   seg_end[0] <= cfg_wdata;
          stip_pkg::REG_END_Y:   seg_end[1] <= cfg_wdata;
          stip_pkg::REG_END_Z:   seg_end[2] <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_crossings.push_back(plane_crossing(widen(in_v0_x, in_v0_y, in_v0_z),
                                                    widen(in_v1_x, in_v1_y, in_v1_z),
                                                    widen(in_v2_x, in_v2_y, in_v2_z)));
      if (out_valid && out_ready) begin
        if (expected_crossings.size() == 0) begin
          $display("%0t: unexpected result beat hit=%b t=%h", $time, out_hit, out_t_param);
          errors <= errors + 1;
        end else begin
          crossing_t e;
          e = expected_crossings.pop_front();
          if (e.hit !== out_hit || e.t !== out_t_param || e.x !== out_hit_x ||
              e.y !== out_hit_y || e.z !== out_hit_z) begin
            $display({"%0t: mismatch expected hit=%b t=%h p=(%h,%h,%h)",
                      " actual hit=%b t=%h p=(%h,%h,%h)"},
                     $time, e.hit, e.t, e.x, e.y, e.z,
                     out_hit, out_t_param, out_hit_x, out_hit_y, out_hit_z);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/tb_segment_triangle_intersection.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment/triangle intersection testbench
// Loads a series of pick segments, the extremes among them, and streams
// directed and random triangles through the block under random back-pressure,
// while the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_segment_triangle_intersection;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ONE = 65536;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_v [9];
  logic        out_valid;
  logic        out_ready;
  logic        out_hit;
  logic [16:0] out_t_param;
  logic [31:0] out_hit_x, out_hit_y, out_hit_z;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_wdata;
  int          errors;
  int          pending;
  int          cycles;
  bit          quiet;
  int          hold_req;
  int          hold_done;
  longint      seg_s [3];
  longint      seg_e [3];

  segment_triangle_intersection u_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_v0_x(in_v[0]), .in_v0_y(in_v[1]), .in_v0_z(in_v[2]),
    .in_v1_x(in_v[3]), .in_v1_y(in_v[4]), .in_v1_z(in_v[5]),
    .in_v2_x(in_v[6]), .in_v2_y(in_v[7]), .in_v2_z(in_v[8]),
    .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
    .out_t_param(out_t_param), .out_hit_x(out_hit_x), .out_hit_y(out_hit_y),
    .out_hit_z(out_hit_z), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  stip_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_v0_x(in_v[0]), .in_v0_y(in_v[1]), .in_v0_z(in_v[2]),
    .in_v1_x(in_v[3]), .in_v1_y(in_v[4]), .in_v1_z(in_v[5]),
    .in_v2_x(in_v[6]), .in_v2_y(in_v[7]), .in_v2_z(in_v[8]),
    .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
    .out_t_param(out_t_param), .out_hit_x(out_hit_x), .out_hit_y(out_hit_y),
    .out_hit_z(out_hit_z), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    hold_done = 0;
    forever begin
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, longint value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value[31:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_segment(longint sx, longint sy, longint sz,
                             longint ex, longint ey, longint ez);
    seg_s = '{sx, sy, sz};
    seg_e = '{ex, ey, ez};
    write_reg(stip_pkg::REG_START_X, sx);
    write_reg(stip_pkg::REG_START_Y, sy);
    write_reg(stip_pkg::REG_START_Z, sz);
    write_reg(stip_pkg::REG_END_X, ex);
    write_reg(stip_pkg::REG_END_Y, ey);
    write_reg(stip_pkg::REG_END_Z, ez);
  endtask

  task automatic send_triangle(longint a [9]);
    in_valid <= 1'b1;
    foreach (a[k]) in_v[k] <= a[k][31:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (stip_pkg::LAT_TOTAL + 8) @(posedge clk);
  endtask

  // Triangle scattered about a random point of the segment, so many are hit.
  task automatic send_near_segment(longint spread);
    longint a [9];
    longint frac;
    frac = $urandom_range(0, ONE);
    for (int k = 0; k < 3; k++) begin
      longint c;
      c = seg_s[k] + (((seg_e[k] - seg_s[k]) * frac) >>> 16);
      for (int v = 0; v < 3; v++)
        a[v * 3 + k] = c + longint'($urandom_range(0, 2 * spread)) - spread;
    end
    send_triangle(a);
  endtask

  task automatic send_noise();
    longint a [9];
    foreach (a[k]) a[k] = longint'($signed($urandom()));
    send_triangle(a);
  endtask

  task automatic random_phase(int count);
    repeat (count) begin
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_near_segment(longint'($urandom_range(1, 1 << $urandom_range(4, 24))));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    foreach (in_v[k]) in_v[k] = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    cycles = 0;
    quiet = 1'b0;
    hold_req = 0;
    seg_s = '{0, 0, 0};
    seg_e = '{0, 0, 0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Segment of zero length after reset: nothing can cross.
    send_triangle('{0, 0, 0, ONE, 0, 0, 0, ONE, 0});
    send_triangle('{-2147483648, 2147483647, -2147483648, 2147483647, -2147483648,
                    2147483647, 0, -1, 1});
    drain();

    set_segment(0, 0, -4 * ONE, 0, 0, 4 * ONE);
    send_triangle('{-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0});
    send_triangle('{-ONE, ONE, 0, 0, -ONE, 0, ONE, ONE, 0});
    send_triangle('{ONE, ONE, 0, 3 * ONE, ONE, 0, 2 * ONE, 3 * ONE, 0});
    send_triangle('{0, 0, 0, ONE, 0, ONE, 0, 0, 2 * ONE});
    send_triangle('{-ONE, -ONE, 100 * ONE, ONE, -ONE, 100 * ONE, 0, ONE, 100 * ONE});
    send_triangle('{-ONE, -ONE, -4 * ONE, ONE, -ONE, -4 * ONE, 0, ONE, -4 * ONE});
    send_triangle('{-ONE, -ONE, 4 * ONE, ONE, -ONE, 4 * ONE, 0, ONE, 4 * ONE});
    send_triangle('{0, 0, 0, ONE, 0, 0, 0, ONE, 0});
    send_triangle('{-ONE, 0, 0, ONE, 0, 0, 0, ONE, 0});
    send_triangle('{0, 0, 0, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE});
    send_triangle('{-ONE, -ONE, -ONE, ONE, -ONE, ONE, 0, ONE, 3});
    send_triangle('{-7, -5, 1, 11, -3, 2, 1, 9, -1});
    drain();
    hold_req = hold_req + 1;
    random_phase(150);
    drain();

    set_segment(-2147483648, -2147483648, -2147483648,
                2147483647, 2147483647, 2147483647);
    send_triangle('{-2147483648, 2147483647, 0, 2147483647, -2147483648, 0,
                    2147483647, 2147483647, 0});
    send_triangle('{2147483647, 2147483647, 2147483647, -2147483648, 2147483647,
                    -2147483648, 2147483647, -2147483648, -2147483648});
    random_phase(80);
    drain();

    set_segment(2147483647, 0, -2147483648, -2147483648, 5, 2147483647);
    random_phase(60);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      longint c [6];
      foreach (c[k]) c[k] = longint'($signed($urandom())) >>> $urandom_range(0, 16);
      set_segment(c[0], c[1], c[2], c[3], c[4], c[5]);
      if (ph == 2) quiet = 1'b1;
      random_phase(80);
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
